// File: sv/handle_table_engine_assert.svh
// Assertion macros for the handle table engine.
`ifndef HANDLE_TABLE_ENGINE_ASSERT_SVH
`define HANDLE_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define HTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/hte_pkg.sv
// Package for the handle table engine: sizes, codes, transaction types, free-slot search.
`timescale 1ns / 1ps

package hte_pkg;

  localparam int unsigned SLOT_COUNT = 64;
  localparam int unsigned IDX_W      = $clog2(SLOT_COUNT);
  localparam logic [1:0]  ALIGN_MASK = 2'd3;

  localparam int unsigned OBJ_W    = 16;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned KIND_W   = 8;
  localparam int unsigned ENTRY_W  = OBJ_W + ACC_W + KIND_W;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_CLOSE  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_PARAM  = 3'd1,
    ST_BAD_HANDLE = 3'd2,
    ST_DENIED     = 3'd3,
    ST_KIND       = 3'd4,
    ST_FULL       = 3'd5
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] handle_in;
    logic [15:0] object_id;
    logic [31:0] access_bits;
    logic [7:0]  object_kind;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  handle_out;
    logic [15:0] object_out;
    logic [5:0]  used_count;
  } rsp_t;

  typedef struct packed {
    logic [OBJ_W-1:0]  object;
    logic [ACC_W-1:0]  access;
    logic [KIND_W-1:0] kind;
  } entry_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } free_t;

  // Lowest clear bit from index 1 upward; slot 0 is reserved.
  function automatic free_t find_free(input logic [SLOT_COUNT-1:0] valid);
    free_t res;
    res.found = 1'b0;
    res.idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 1; i--) begin
      if (!valid[i]) begin
        res.found = 1'b1;
        res.idx   = IDX_W'(i);
      end
    end
    return res;
  endfunction

endpackage

// File: sv/hte_slot_ram.sv
// Single-port-write, registered-read RAM holding the slot entries.
`timescale 1ns / 1ps

module hte_slot_ram #(
  parameter int unsigned DATA_W = 56,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/handle_table_engine.sv
// Handle table engine: first-free handle allocator with lookup, close and clear.
// Flow: the slot RAM is read on the accepting edge, then the execute step registers the result
//   once the output can take it; a new transaction is accepted only after that execute step,
//   which checks, writes back and updates the valid vector.
// Reset: valid vector, slot count, FSM and output valid clear at once; the slot RAM is
//   not cleared and needs no clearing pass, empty slots are marked by the valid vector.
`timescale 1ns / 1ps
`include "handle_table_engine_assert.svh"

module handle_table_engine
  import hte_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q, rsp_d;
  logic   out_valid_q;

  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]      count_q, count_d;

  logic   accept;
  logic   can_issue;
  logic   exec_fire;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  logic [13:0]      hidx;
  logic [IDX_W-1:0] idx_q;
  logic             handle_ok;
  free_t            free_slot;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (can_issue) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready_o = 1'b0;
    exec_fire  = 1'b0;
    case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_EXEC:  exec_fire  = can_issue;
      default: ;
    endcase
  end

  assign accept    = in_valid_i & in_ready_o;
  assign can_issue = !out_valid_q || out_ready_i;

  hte_slot_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (accept),
    .rd_addr_i (in_data_i.handle_in[IDX_W+1:2]),
    .rd_data_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  assign hidx      = req_q.handle_in[15:2];
  assign idx_q     = req_q.handle_in[IDX_W+1:2];
  assign handle_ok = ((req_q.handle_in[1:0] & ALIGN_MASK) == 2'd0) && (hidx != 14'd0) &&
                     (hidx < 14'(SLOT_COUNT)) && valid_q[idx_q];
  assign free_slot = find_free(valid_q);

  // Execute step: checks, write-back and result
  always_comb begin
    valid_d          = valid_q;
    count_d          = count_q;
    ram_we           = 1'b0;
    ram_waddr        = free_slot.idx;
    ram_wdata.object = req_q.object_id;
    ram_wdata.access = req_q.access_bits;
    ram_wdata.kind   = req_q.object_kind;
    rsp_d            = '0;
    rsp_d.status     = ST_OK;
    case (func_e'(req_q.func))
      FUNC_INSERT: begin
        if (req_q.object_id == '0) begin
          rsp_d.status = ST_BAD_PARAM;
        end else if (!free_slot.found) begin
          rsp_d.status = ST_FULL;
        end else begin
          ram_we                   = 1'b1;
          valid_d[free_slot.idx]   = 1'b1;
          count_d                  = count_q + 1'b1;
          rsp_d.handle_out         = 8'({free_slot.idx, 2'b00});
        end
      end
      FUNC_LOOKUP: begin
        if (!handle_ok) begin
          rsp_d.status = ST_BAD_HANDLE;
        end else if ((req_q.access_bits != '0) &&
                     ((ram_rdata.access & req_q.access_bits) != req_q.access_bits)) begin
          rsp_d.status = ST_DENIED;
        end else if ((req_q.object_kind != '0) && (ram_rdata.kind != req_q.object_kind)) begin
          rsp_d.status = ST_KIND;
        end else begin
          rsp_d.object_out = ram_rdata.object;
        end
      end
      FUNC_CLOSE: begin
        if (!handle_ok) begin
          rsp_d.status = ST_BAD_HANDLE;
        end else begin
          valid_d[idx_q] = 1'b0;
          if (count_q != '0) count_d = count_q - 1'b1;
        end
      end
      FUNC_CLEAR: begin
        valid_d = '0;
        count_d = '0;
      end
      default: ;
    endcase
    if (!exec_fire) begin
      ram_we  = 1'b0;
      valid_d = valid_q;
      count_d = count_q;
    end
    rsp_d.used_count = 6'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      count_q <= count_d;
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_data_i;
    if (exec_fire) rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  `HTE_ASSERT_IMP(a_count_matches, 1'b1, $countones(valid_q) == int'(count_q), "slot count out of step with valid vector")
  `HTE_ASSERT_IMP(a_slot0_free, 1'b1, !valid_q[0], "reserved slot zero marked used")
  `HTE_ASSERT_NXT(a_exec_result, exec_fire, out_valid_o, "executed transaction produced no result")

endmodule
